### rtl/core/oest_pkg.sv
// ============================================================================
// oest_pkg: shared constants for the oscillation extremum stimulus trigger
// Widths, register indexes, reset values, slope and extremum codes, warm-up limit.
// ============================================================================
package oest_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int THRESH_BITS    = 16;
    localparam int TICK_CFG_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_CYCLE_TICKS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_CYCLE_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STIM_DURATION_TICKS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STIM_ON_TROUGH      = 3'd4;

    localparam logic [THRESH_BITS-1:0]   RST_AMPLITUDE_THRESHOLD = 16'd0;
    localparam logic [TICK_CFG_BITS-1:0] RST_HALF_CYCLE_TICKS    = 32'd62;
    localparam logic [TICK_CFG_BITS-1:0] RST_FULL_CYCLE_TICKS    = 32'd125;
    localparam logic [TICK_CFG_BITS-1:0] RST_STIM_DURATION_TICKS = 32'd10;
    localparam logic                     RST_STIM_ON_TROUGH      = 1'b0;

    // Slope sign of the sample difference
    typedef enum logic [1:0] {
        SLOPE_FLAT = 2'b00,
        SLOPE_UP   = 2'b01,
        SLOPE_DOWN = 2'b10
    } slope_t;

    // Extremum report codes
    localparam logic [1:0] EXT_NONE   = 2'd0;
    localparam logic [1:0] EXT_PEAK   = 2'd1;
    localparam logic [1:0] EXT_TROUGH = 2'd2;

    // Warm-up count saturates here
    localparam logic [1:0] WARMUP_DONE = 2'd2;

endpackage

### rtl/core/oscillation_extremum_stimulus_trigger_unit.sv
// ============================================================================
// oscillation_extremum_stimulus_trigger_unit
// Slope-sign peak/trough detector that gates a stimulus output.
// ============================================================================
//
// Channel   | Direction | Signals                      | Contents
// ----------+-----------+------------------------------+-------------------------
// s_*       | in        | s_tvalid s_tready s_tdata    | sample (signed)
// m_*       | out       | m_tvalid m_tready m_tdata    | stimulus, extremum_found
// cfg_*     | in        | cfg_we cfg_index cfg_data    | register writes
//
// Cycles: one sample per clock sustained while m_tready stays high. A transfer
// lands in the input register, is evaluated there by the slope/threshold/counter
// logic, and its result is loaded into the output register when that slot is free
// or drains. The detector state updates as the result is loaded.
// Reset: asynchronous, active low; clears all detector state and the
// configuration registers to their defaults. No clearing pass.
// Stalls: while m_tready is low with a result waiting, one more sample is
// held in the input register; s_tready drops only when both are full.
// ============================================================================
module oscillation_extremum_stimulus_trigger_unit #(
    parameter int SAMPLE_BITS = oest_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = oest_pkg::TIME_BITS_DEF,
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_TDATA_BITS-1:0]           s_tdata,   // [SAMPLE_BITS-1:0] sample

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] stimulus,
                                                         // [2:1] extremum_found

    input  logic                              cfg_we,
    input  logic [oest_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [oest_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int TB       = oest_pkg::TICK_CFG_BITS;
    localparam int CMP_BITS = (TIME_BITS > TB) ? TIME_BITS : TB;
    localparam int MAG_BITS = (SAMPLE_BITS > oest_pkg::THRESH_BITS) ?
                              SAMPLE_BITS : oest_pkg::THRESH_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [oest_pkg::THRESH_BITS-1:0] amp_thresh_reg;
    logic [TB-1:0]                    half_ticks_reg;
    logic [TB-1:0]                    full_ticks_reg;
    logic [TB-1:0]                    dur_ticks_reg;
    logic                             on_trough_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_thresh_reg <= oest_pkg::RST_AMPLITUDE_THRESHOLD;
            half_ticks_reg <= oest_pkg::RST_HALF_CYCLE_TICKS;
            full_ticks_reg <= oest_pkg::RST_FULL_CYCLE_TICKS;
            dur_ticks_reg  <= oest_pkg::RST_STIM_DURATION_TICKS;
            on_trough_reg  <= oest_pkg::RST_STIM_ON_TROUGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                oest_pkg::REG_AMPLITUDE_THRESHOLD:
                    amp_thresh_reg <= cfg_data[oest_pkg::THRESH_BITS-1:0];
                oest_pkg::REG_HALF_CYCLE_TICKS:    half_ticks_reg <= cfg_data[TB-1:0];
                oest_pkg::REG_FULL_CYCLE_TICKS:    full_ticks_reg <= cfg_data[TB-1:0];
                oest_pkg::REG_STIM_DURATION_TICKS: dur_ticks_reg  <= cfg_data[TB-1:0];
                oest_pkg::REG_STIM_ON_TROUGH:      on_trough_reg  <= cfg_data[0];
                default: ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the evaluation, output register
    // holds the result. Advance whenever the output slot is free or drains.
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          out_valid_reg;
    logic                          stim_out_reg;
    logic [1:0]                    ext_out_reg;
    logic                          advance;
    logic                          in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg;
    oest_pkg::slope_t              prev_slope_reg;
    logic [1:0]                    warmup_reg;
    logic [TIME_BITS-1:0]          tse_reg;   // since any accepted extremum
    logic [TIME_BITS-1:0]          tsp_reg;   // since accepted peak
    logic [TIME_BITS-1:0]          tst_reg;   // since accepted trough
    logic [TIME_BITS-1:0]          tss_reg;   // since stimulus start
    logic                          refr_reg;

    // ------------------------------------------------------------------
    // Evaluation of the sample in the input register
    // ------------------------------------------------------------------
    oest_pkg::slope_t      slope;
    logic [SAMPLE_BITS-1:0] mag;
    logic                  warm;
    logic                  sign_change;
    logic                  gate_ok;
    logic                  peak_ok;
    logic                  trough_ok;
    logic                  refr_live;
    logic                  trigger;
    logic                  refr_next;
    logic [1:0]            ext_next;
    logic [TIME_BITS-1:0]  tse_next;
    logic [TIME_BITS-1:0]  tsp_next;
    logic [TIME_BITS-1:0]  tst_next;
    logic [TIME_BITS-1:0]  tss_next;

    function automatic logic [TIME_BITS-1:0] count_next(
        input logic [TIME_BITS-1:0] cnt,
        input logic                 restart
    );
        logic [TIME_BITS-1:0] res;
        if (restart)
            res = {{(TIME_BITS-1){1'b0}}, 1'b1};
        else if (cnt == TIME_MAX)
            res = cnt;
        else
            res = cnt + 1'b1;
        return res;
    endfunction

    always_comb
    begin
        // slope sign of the new difference
        if (sample_reg > prev_sample_reg)
            slope = oest_pkg::SLOPE_UP;
        else if (sample_reg < prev_sample_reg)
            slope = oest_pkg::SLOPE_DOWN;
        else
            slope = oest_pkg::SLOPE_FLAT;

        // magnitude; the most negative value maps to 2^(SAMPLE_BITS-1)
        mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;

        warm        = (warmup_reg == oest_pkg::WARMUP_DONE);
        sign_change = (slope != prev_slope_reg);
        gate_ok     = warm && sign_change
                   && (CMP_BITS'(tse_reg) >= CMP_BITS'(half_ticks_reg))
                   && (MAG_BITS'(mag) >= MAG_BITS'(amp_thresh_reg));
        peak_ok     = gate_ok && (slope == oest_pkg::SLOPE_DOWN)
                   && (CMP_BITS'(tsp_reg) >= CMP_BITS'(full_ticks_reg));
        trough_ok   = gate_ok && (slope == oest_pkg::SLOPE_UP)
                   && (CMP_BITS'(tst_reg) >= CMP_BITS'(full_ticks_reg));

        // drop refractory once elapsed time exceeds the duration
        refr_live = refr_reg && !(CMP_BITS'(tss_reg) > CMP_BITS'(dur_ticks_reg));
        trigger   = !refr_live && (on_trough_reg ? trough_ok : peak_ok);
        refr_next = refr_live || trigger;

        if (peak_ok)
            ext_next = oest_pkg::EXT_PEAK;
        else if (trough_ok)
            ext_next = oest_pkg::EXT_TROUGH;
        else
            ext_next = oest_pkg::EXT_NONE;

        tse_next = count_next(tse_reg, peak_ok || trough_ok);
        tsp_next = count_next(tsp_reg, peak_ok);
        tst_next = count_next(tst_reg, trough_ok);
        tss_next = count_next(tss_reg, trigger);
    end

    // ------------------------------------------------------------------
    // State and result update on advance
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_slope_reg  <= oest_pkg::SLOPE_FLAT;
            warmup_reg      <= 2'd0;
            tse_reg         <= '0;
            tsp_reg         <= '0;
            tst_reg         <= '0;
            tss_reg         <= '0;
            refr_reg        <= 1'b0;
        end
        else if (advance)
        begin
            prev_sample_reg <= sample_reg;
            prev_slope_reg  <= slope;
            if (!warm)
            begin
                warmup_reg <= warmup_reg + 2'd1;
            end
            tse_reg  <= tse_next;
            tsp_reg  <= tsp_next;
            tst_reg  <= tst_next;
            tss_reg  <= tss_next;
            refr_reg <= refr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stim_out_reg <= refr_next;
            ext_out_reg  <= ext_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, ext_out_reg, stim_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty output slot never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // No extremum is reported during warm-up.
    a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !warm) |-> (ext_next == oest_pkg::EXT_NONE))
        else $error("extremum reported during warm-up");

    // A stimulus that starts from idle comes with an extremum of the chosen kind.
    a_trigger_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !refr_reg && refr_next) |->
            ((on_trough_reg && ext_next == oest_pkg::EXT_TROUGH) ||
             (!on_trough_reg && ext_next == oest_pkg::EXT_PEAK)))
        else $error("stimulus started without matching extremum");

    // An accepted peak restarts its counter.
    a_peak_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && peak_ok) |=> (tsp_reg == {{(TIME_BITS-1){1'b0}}, 1'b1}))
        else $error("peak counter not restarted");

endmodule
